// ===== design/qmm_pkg.sv =====
// ----------------------------------------------------------------------------
// qmm_pkg: shared definitions for the quantized matrix multiply block
// Sizes, input codes, register indexes and the structs passed between units.
// ----------------------------------------------------------------------------
`default_nettype none

package qmm_pkg;

  localparam int MAX_DIM    = 64;
  localparam int DATA_BITS  = 8;
  localparam int IDX_BITS   = $clog2(MAX_DIM);
  localparam int DIM_BITS   = IDX_BITS + 1;
  localparam int ADDR_BITS  = 2 * IDX_BITS;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int PROD_BITS  = 2 * DATA_BITS;
  localparam int ACC_BITS   = 32;
  localparam int RND_BITS   = ACC_BITS + 2;
  localparam int SHIFT_BITS = 5;
  localparam int KIND_BITS  = 2;
  localparam int CIDX_BITS  = 3;
  localparam int CDATA_BITS = 8;

  localparam logic [KIND_BITS-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_COMPUTE = 2'd2;

  localparam logic [CIDX_BITS-1:0] REG_SHIFT     = 3'd0;
  localparam logic [CIDX_BITS-1:0] REG_NUM_ROWS  = 3'd1;
  localparam logic [CIDX_BITS-1:0] REG_INNER_DIM = 3'd2;
  localparam logic [CIDX_BITS-1:0] REG_NUM_COLS  = 3'd3;
  localparam logic [CIDX_BITS-1:0] REG_SAT_HIGH  = 3'd4;
  localparam logic [CIDX_BITS-1:0] REG_SAT_LOW   = 3'd5;

  typedef struct packed {
    logic [SHIFT_BITS-1:0]       shift;
    logic [DIM_BITS-1:0]         num_rows;
    logic [DIM_BITS-1:0]         inner_dim;
    logic [DIM_BITS-1:0]         num_cols;
    logic signed [DATA_BITS-1:0] sat_high;
    logic signed [DATA_BITS-1:0] sat_low;
  } cfg_t;

  // tag that travels with each multiply-accumulate op down the pipe
  typedef struct packed {
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic                first;
    logic                last_k;
    logic                last_col;
    logic                zero;
  } tag_t;

  typedef struct packed {
    logic                 wr_a;
    logic                 wr_b;
    logic                 clr;
    logic [ADDR_BITS-1:0] clr_addr;
    logic                 rd_en;
    logic [IDX_BITS-1:0]  k;
    tag_t                 tag;
  } cmd_t;

  function automatic logic [DIM_BITS-1:0] clip_dim(input logic [DIM_BITS-1:0] d);
    clip_dim = (d > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : d;
  endfunction

endpackage

`default_nettype wire

// ===== design/quantized_matrix_multiply_top.sv =====
// ----------------------------------------------------------------------------
// quantized_matrix_multiply_top: int8 matrix multiply, one row of C a request
// A load request writes one element; busy stays low.
// A compute request keeps busy high while it issues one MAC per cycle
// through the single read port of each store; result j leaves the read,
// multiply, accumulate, round and clamp registers after its last MAC, one
// per strobe, and the receiver cannot stall. Reset clears both 4096-entry
// stores, one entry a cycle: busy is high and config writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_matrix_multiply_top import qmm_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [KIND_BITS-1:0]        kind,
  input  wire logic [IDX_BITS-1:0]         row_index,
  input  wire logic [IDX_BITS-1:0]         col_index,
  input  wire logic signed [DATA_BITS-1:0] elem_value,
  // results, one cycle each
  output logic                             out_strobe,
  output logic [IDX_BITS-1:0]              out_row,
  output logic [IDX_BITS-1:0]              out_col,
  output logic signed [DATA_BITS-1:0]      out_value,
  output logic                             last,
  // configuration writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CIDX_BITS-1:0]        cfg_index,
  input  wire logic [CDATA_BITS-1:0]       cfg_data
);

  cfg_t cfg;
  cmd_t cmd;

  // register file: shift, dimensions, clamp limits
  qmm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: clear sweep, request decode, k/column stepping
  qmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .row_index (row_index),
    .cfg       (cfg),
    .cmd       (cmd)
  );

  // stores plus read / multiply / accumulate / round / clamp pipe
  qmm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .row_index  (row_index),
    .col_index  (col_index),
    .elem_value (elem_value),
    .out_strobe (out_strobe),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .last       (last)
  );

endmodule

`default_nettype wire

// ===== design/qmm_regs.sv =====
// ----------------------------------------------------------------------------
// qmm_regs: configuration register file
// Holds shift, dimensions and clamp limits; write-only, always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module qmm_regs import qmm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CIDX_BITS-1:0]  cfg_index,
  input  wire logic [CDATA_BITS-1:0] cfg_data,
  output cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shift     <= '0;
      cfg.num_rows  <= DIM_BITS'(MAX_DIM);
      cfg.inner_dim <= DIM_BITS'(MAX_DIM);
      cfg.num_cols  <= DIM_BITS'(MAX_DIM);
      cfg.sat_high  <= DATA_BITS'(127);
      cfg.sat_low   <= DATA_BITS'(-128);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHIFT:     cfg.shift     <= cfg_data[SHIFT_BITS-1:0];
        REG_NUM_ROWS:  cfg.num_rows  <= cfg_data[DIM_BITS-1:0];
        REG_INNER_DIM: cfg.inner_dim <= cfg_data[DIM_BITS-1:0];
        REG_NUM_COLS:  cfg.num_cols  <= cfg_data[DIM_BITS-1:0];
        REG_SAT_HIGH:  cfg.sat_high  <= cfg_data[DATA_BITS-1:0];
        REG_SAT_LOW:   cfg.sat_low   <= cfg_data[DATA_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/qmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// qmm_ctrl: sequencer for the matrix multiply
// Clears the stores after reset, decodes requests, steps k and column.
// ----------------------------------------------------------------------------
`default_nettype none

module qmm_ctrl import qmm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [KIND_BITS-1:0] kind,
  input  wire logic [IDX_BITS-1:0]  row_index,
  input  wire cfg_t                 cfg,
  output cmd_t                      cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0]           state, state_next;
  logic [ADDR_BITS-1:0] clr_cnt;
  logic [IDX_BITS-1:0]  k, k_next;
  logic [IDX_BITS-1:0]  col, col_next;
  logic [IDX_BITS-1:0]  row, row_next;
  logic [DIM_BITS-1:0]  rows_eff, kdim_eff, cols_eff, kdim_m1, cols_m1;
  logic                 accept, kzero, last_k, last_col, go;

  assign rows_eff = clip_dim(cfg.num_rows);
  assign kdim_eff = clip_dim(cfg.inner_dim);
  assign cols_eff = clip_dim(cfg.num_cols);
  assign kdim_m1  = kdim_eff - DIM_BITS'(1);
  assign cols_m1  = cols_eff - DIM_BITS'(1);
  assign kzero    = (kdim_eff == '0);

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign go     = accept && (kind == KIND_COMPUTE) &&
                  ({1'b0, row_index} < rows_eff) && (cols_eff != '0);

  assign last_k   = kzero || (k == kdim_m1[IDX_BITS-1:0]);
  assign last_col = (col == cols_m1[IDX_BITS-1:0]);

  always_comb begin
    state_next = state;
    k_next     = k;
    col_next   = col;
    row_next   = row;
    case (state)
      ST_CLEAR: begin
        if (&clr_cnt) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (go) begin
          state_next = ST_RUN;
          k_next     = '0;
          col_next   = '0;
          row_next   = row_index;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          k_next = '0;
          if (last_col) state_next = ST_IDLE;
          else col_next = col + IDX_BITS'(1);
        end else begin
          k_next = k + IDX_BITS'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      k       <= '0;
      col     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      col   <= col_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    row <= row_next;
  end

  always_comb begin
    cmd.wr_a         = accept && (kind == KIND_LOAD_A);
    cmd.wr_b         = accept && (kind == KIND_LOAD_B);
    cmd.clr          = (state == ST_CLEAR);
    cmd.clr_addr     = clr_cnt;
    cmd.rd_en        = (state == ST_RUN);
    cmd.k            = k;
    cmd.tag.row      = row;
    cmd.tag.col      = col;
    cmd.tag.first    = (k == '0);
    cmd.tag.last_k   = last_k;
    cmd.tag.last_col = last_col;
    cmd.tag.zero     = kzero;
  end

endmodule

`default_nettype wire

// ===== design/qmm_datapath.sv =====
// ----------------------------------------------------------------------------
// qmm_datapath: element stores and multiply-accumulate pipe
// Read, multiply, accumulate, round-shift, clamp; one result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qmm_datapath import qmm_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cmd_t                        cmd,
  input  wire cfg_t                        cfg,
  input  wire logic [IDX_BITS-1:0]         row_index,
  input  wire logic [IDX_BITS-1:0]         col_index,
  input  wire logic signed [DATA_BITS-1:0] elem_value,
  output logic                             out_strobe,
  output logic [IDX_BITS-1:0]              out_row,
  output logic [IDX_BITS-1:0]              out_col,
  output logic signed [DATA_BITS-1:0]      out_value,
  output logic                             last
);

  logic signed [DATA_BITS-1:0] a_mem [DEPTH];
  logic signed [DATA_BITS-1:0] b_mem [DEPTH];

  logic [ADDR_BITS-1:0]        wr_addr;
  logic signed [DATA_BITS-1:0] wr_data;

  assign wr_addr = cmd.clr ? cmd.clr_addr : {row_index, col_index};
  assign wr_data = cmd.clr ? '0 : elem_value;

  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.wr_a) a_mem[wr_addr] <= wr_data;
    if (cmd.clr || cmd.wr_b) b_mem[wr_addr] <= wr_data;
  end

  // stage 1: registered store reads
  logic                        v1;
  tag_t                        t1;
  logic signed [DATA_BITS-1:0] a_q, b_q;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_q <= a_mem[{cmd.tag.row, cmd.k}];
      b_q <= b_mem[{cmd.k, cmd.tag.col}];
    end
    t1 <= cmd.tag;
  end

  // stage 2: product, signed 8x8
  logic                        v2;
  tag_t                        t2;
  logic signed [PROD_BITS-1:0] prod, prod_raw;

  assign prod_raw = a_q * b_q;

  always_ff @(posedge clk) begin
    prod <= t1.zero ? '0 : prod_raw;
    t2   <= t1;
  end

  // stage 3: accumulate, wraps at 32 bits
  logic                       v3;
  tag_t                       t3;
  logic signed [ACC_BITS-1:0] acc, prod_ext, acc_next;

  assign prod_ext = {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};
  assign acc_next = t2.first ? prod_ext : acc + prod_ext;

  always_ff @(posedge clk) begin
    if (v2) acc <= acc_next;
    t3 <= t2;
  end

  // stage 4: round half up, arithmetic shift
  logic                       v4;
  tag_t                       t4;
  logic signed [RND_BITS-1:0] rnd, sum_r, shifted;

  assign rnd   = (cfg.shift == '0) ? '0 :
                 (RND_BITS'(1) << (cfg.shift - SHIFT_BITS'(1)));
  assign sum_r = {{(RND_BITS-ACC_BITS){acc[ACC_BITS-1]}}, acc} + rnd;

  always_ff @(posedge clk) begin
    shifted <= sum_r >>> cfg.shift;
    t4      <= t3;
  end

  // stage 5: clamp, upper limit first
  logic signed [RND_BITS-1:0] hi_ext, lo_ext, clamp_hi, clamp_lo;

  assign hi_ext   = {{(RND_BITS-DATA_BITS){cfg.sat_high[DATA_BITS-1]}}, cfg.sat_high};
  assign lo_ext   = {{(RND_BITS-DATA_BITS){cfg.sat_low[DATA_BITS-1]}}, cfg.sat_low};
  assign clamp_hi = (shifted > hi_ext) ? hi_ext : shifted;
  assign clamp_lo = (clamp_hi < lo_ext) ? lo_ext : clamp_hi;

  always_ff @(posedge clk) begin
    out_row   <= t4.row;
    out_col   <= t4.col;
    out_value <= clamp_lo[DATA_BITS-1:0];
    last      <= t4.last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      v1         <= cmd.rd_en;
      v2         <= v1;
      v3         <= v2 && t2.last_k;
      v4         <= v3;
      out_strobe <= v4;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for quantized_matrix_multiply_top
// Drives load and compute requests, keeps its own copy of both matrices and
// the register file, and checks every strobed element of C against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import qmm_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 9;
  // quiet time before a register write; covers the output pipe
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 32;
  // longest correct silence: the store clear after reset, or one full
  // 64-deep dot product between strobes; taken several times over
  localparam int QUIET_LIMIT    = 20000;
  localparam int PHASES         = 9;
  localparam int REQS_PER_PHASE = 34;

  // request kind with no meaning; the block swallows it
  localparam logic [KIND_BITS-1:0] KIND_UNUSED   = 2'd3;
  // register indexes past the end of the file; writes are dropped
  localparam logic [CIDX_BITS-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CIDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

  // one element of C as it leaves the block
  typedef struct packed {
    logic [IDX_BITS-1:0]         row;
    logic [IDX_BITS-1:0]         col;
    logic signed [DATA_BITS-1:0] value;
    logic                        last;
  } c_elem_t;

  typedef enum logic {STEP_REQUEST, STEP_REG_WRITE} step_e;

  // one row of the directed table; a register write keeps its index in row
  typedef struct packed {
    step_e                       op;
    logic [KIND_BITS-1:0]        kind;
    logic [IDX_BITS-1:0]         row;
    logic [IDX_BITS-1:0]         col;
    logic [DATA_BITS-1:0]        data;
    logic                        typed;
    logic signed [DATA_BITS-1:0] typed_value;
  } step_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [KIND_BITS-1:0]        kind;
  logic [IDX_BITS-1:0]         row_index;
  logic [IDX_BITS-1:0]         col_index;
  logic signed [DATA_BITS-1:0] elem_value;
  logic                        out_strobe;
  logic [IDX_BITS-1:0]         out_row;
  logic [IDX_BITS-1:0]         out_col;
  logic signed [DATA_BITS-1:0] out_value;
  logic                        last;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CIDX_BITS-1:0]        cfg_index;
  logic [CDATA_BITS-1:0]       cfg_data;

  // bench copy of both matrices and of the register file
  logic signed [DATA_BITS-1:0] a_mat [DEPTH];
  logic signed [DATA_BITS-1:0] b_mat [DEPTH];
  logic [SHIFT_BITS-1:0]       cur_shift;
  logic [DIM_BITS-1:0]         cur_rows;
  logic [DIM_BITS-1:0]         cur_inner;
  logic [DIM_BITS-1:0]         cur_cols;
  logic signed [DATA_BITS-1:0] cur_hi;
  logic signed [DATA_BITS-1:0] cur_lo;

  c_elem_t pending_elems [$];
  step_t   directed [$];
  int      err_count;
  int      quiet_cycles;

  quantized_matrix_multiply_top uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .row_index  (row_index),
    .col_index  (col_index),
    .elem_value (elem_value),
    .out_strobe (out_strobe),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // dimension registers are 7 bits wide but saturate at the store size
  function automatic int eff_dim(input logic [DIM_BITS-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // C[r][c]: 32-bit wrapping dot product, round-half-up shift, then the
  // upper clamp before the lower one (crossed limits land on sat_low)
  function automatic logic signed [DATA_BITS-1:0] dot_elem(input int r, input int c,
                                                           input int kd);
    int     acc;
    int     prod;
    longint v;
    acc = 0;
    for (int k = 0; k < kd; k++) begin
      prod = a_mat[r * MAX_DIM + k] * b_mat[k * MAX_DIM + c];
      acc += prod;
    end
    v = longint'(acc);
    if (cur_shift != 0) begin
      v = (v + (64'sd1 <<< (cur_shift - 1))) >>> cur_shift;
    end
    if (v > cur_hi) v = cur_hi;
    if (v < cur_lo) v = cur_lo;
    return v[DATA_BITS-1:0];
  endfunction

  // update the bench matrices or queue the row of C a request asks for;
  // a typed row overrides the computed value with the one in the table
  task automatic apply_request(input logic [KIND_BITS-1:0] k, input int r, input int c,
                               input logic signed [DATA_BITS-1:0] v, input logic typed,
                               input logic signed [DATA_BITS-1:0] typed_value);
    int      n_rows;
    int      n_inner;
    int      n_cols;
    c_elem_t e;
    n_rows  = eff_dim(cur_rows);
    n_inner = eff_dim(cur_inner);
    n_cols  = eff_dim(cur_cols);
    case (k)
      KIND_LOAD_A: a_mat[r * MAX_DIM + c] = v;
      KIND_LOAD_B: b_mat[r * MAX_DIM + c] = v;
      KIND_COMPUTE: begin
        if (r < n_rows) begin
          for (int j = 0; j < n_cols; j++) begin
            e.row   = IDX_BITS'(r);
            e.col   = IDX_BITS'(j);
            e.value = typed ? typed_value : dot_elem(r, j, n_inner);
            e.last  = (j == n_cols - 1);
            pending_elems.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  // start stays high on return so back-to-back requests need no gap
  task automatic send_request(input logic [KIND_BITS-1:0] k, input logic [IDX_BITS-1:0] r,
                              input logic [IDX_BITS-1:0] c,
                              input logic signed [DATA_BITS-1:0] v, input logic typed,
                              input logic signed [DATA_BITS-1:0] typed_value);
    if (cfg_valid) cfg_valid <= 1'b0;
    start      <= 1'b1;
    kind       <= k;
    row_index  <= r;
    col_index  <= c;
    elem_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    apply_request(k, r, c, v, typed, typed_value);
  endtask

  // cfg_valid stays high on return; the next request lowers it
  task automatic write_reg(input logic [CIDX_BITS-1:0] idx, input logic [CDATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_SHIFT:     cur_shift = d[SHIFT_BITS-1:0];
      REG_NUM_ROWS:  cur_rows  = d[DIM_BITS-1:0];
      REG_INNER_DIM: cur_inner = d[DIM_BITS-1:0];
      REG_NUM_COLS:  cur_cols  = d[DIM_BITS-1:0];
      REG_SAT_HIGH:  cur_hi    = d;
      REG_SAT_LOW:   cur_lo    = d;
      default: ;
    endcase
  endtask

  // block must be idle before the register file changes
  task automatic settle();
    start <= 1'b0;
    while (pending_elems.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic step_t req_step(input logic [KIND_BITS-1:0] k, input int r,
                                     input int c, input int v);
    return '{STEP_REQUEST, k, IDX_BITS'(r), IDX_BITS'(c), DATA_BITS'(v), 1'b0, '0};
  endfunction

  function automatic step_t typed_step(input int r, input int v);
    return '{STEP_REQUEST, KIND_COMPUTE, IDX_BITS'(r), '0, '0, 1'b1, DATA_BITS'(v)};
  endfunction

  function automatic step_t reg_step(input logic [CIDX_BITS-1:0] idx, input int v);
    return '{STEP_REG_WRITE, '0, IDX_BITS'(idx), '0, DATA_BITS'(v), 1'b0, '0};
  endfunction

  // index inside the live dimension most of the time, anywhere otherwise
  function automatic logic [IDX_BITS-1:0] pick_idx(input int lim);
    if (lim == 0 || $urandom_range(99) < 15) return IDX_BITS'($urandom_range(63));
    return IDX_BITS'($urandom_range(lim - 1));
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_val();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 8'h80;
    if (r < 16) return 8'h7f;
    return DATA_BITS'($urandom_range(255));
  endfunction

  // mostly small, sometimes zero, full size or past full size; the unused
  // top bit of the write data is random
  function automatic logic [CDATA_BITS-1:0] pick_dim();
    int r;
    int d;
    r = $urandom_range(99);
    if (r < 5) d = 0;
    else if (r < 10) d = $urandom_range(127, 65);
    else if (r < 16) d = MAX_DIM;
    else d = $urandom_range(8, 1);
    return {1'($urandom_range(1)), 7'(d)};
  endfunction

  // results come one cycle each and cannot be held off: check on the edge
  always @(posedge clk) begin
    c_elem_t seen;
    c_elem_t want;
    if (!rst && out_strobe === 1'b1) begin
      seen = {out_row, out_col, out_value, last};
      if (pending_elems.size() == 0) begin
        report_mismatch($sformatf("stray element row %0d col %0d value %0d last %0b",
                                  seen.row, seen.col, seen.value, seen.last));
      end else begin
        want = pending_elems.pop_front();
        if (seen.row !== want.row || seen.col !== want.col ||
            seen.value !== want.value || seen.last !== want.last) begin
          report_mismatch($sformatf("got row %0d col %0d value %0d last %0b, want %0d %0d %0d %0b",
                                    seen.row, seen.col, seen.value, seen.last,
                                    want.row, want.col, want.value, want.last));
        end
      end
    end
  end

  // watchdog: any request, strobe or register write counts as progress
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || out_strobe === 1'b1 ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int              p;
    int              r;
    int              s;
    int              counted;
    int              idle_pct;
    int              n_rows;
    int              n_inner;
    int              n_cols;
    bit              prev_reg;
    logic [7:0]      shift_raw;
    logic [7:0]      rows_raw;
    logic [7:0]      inner_raw;
    logic [7:0]      cols_raw;
    logic signed [7:0] hi;
    logic signed [7:0] lo;
    logic signed [7:0] tmp;

    err_count    = 0;
    quiet_cycles = 0;
    prev_reg     = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      a_mat[i] = '0;
      b_mat[i] = '0;
    end
    cur_shift = '0;
    cur_rows  = DIM_BITS'(MAX_DIM);
    cur_inner = DIM_BITS'(MAX_DIM);
    cur_cols  = DIM_BITS'(MAX_DIM);
    cur_hi    = 8'sd127;
    cur_lo    = -8'sd128;

    rst        <= 1'b1;
    start      <= 1'b0;
    kind       <= KIND_LOAD_A;
    row_index  <= '0;
    col_index  <= '0;
    elem_value <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_SHIFT;
    cfg_data   <= '0;

    // Directed table. Typed rows carry a value every element of the row must
    // equal; the rest go through the bench's own dot product.
    // Stores are clear after reset: the last row at full size is all zero.
    directed.push_back(typed_step(63, 0));
    directed.push_back(reg_step(REG_NUM_ROWS, 2));
    directed.push_back(reg_step(REG_INNER_DIM, 2));
    directed.push_back(reg_step(REG_NUM_COLS, 2));
    directed.push_back(req_step(KIND_LOAD_A, 0, 0, -128));
    directed.push_back(req_step(KIND_LOAD_A, 0, 1, -128));
    directed.push_back(req_step(KIND_LOAD_B, 0, 0, -128));
    directed.push_back(req_step(KIND_LOAD_B, 0, 1, -128));
    directed.push_back(req_step(KIND_LOAD_B, 1, 0, -128));
    directed.push_back(req_step(KIND_LOAD_B, 1, 1, -128));
    // (-128)*(-128) twice = 32768, clamps high
    directed.push_back(typed_step(0, 127));
    directed.push_back(req_step(KIND_LOAD_A, 1, 0, 127));
    directed.push_back(req_step(KIND_LOAD_A, 1, 1, 127));
    // 127*(-128) twice, clamps low
    directed.push_back(typed_step(1, -128));
    // row past num_rows, then the unused kind: neither emits anything
    directed.push_back(req_step(KIND_COMPUTE, 2, 0, 0));
    directed.push_back(req_step(KIND_UNUSED, 0, 0, 85));
    // far corners of both stores
    directed.push_back(req_step(KIND_LOAD_A, 63, 63, 127));
    directed.push_back(req_step(KIND_LOAD_A, 63, 2, -1));
    directed.push_back(req_step(KIND_LOAD_B, 2, 63, -128));
    // widest shift rounds 32768 down to zero
    directed.push_back(reg_step(REG_SHIFT, 31));
    directed.push_back(typed_step(0, 0));
    directed.push_back(reg_step(REG_SHIFT, 1));
    directed.push_back(req_step(KIND_COMPUTE, 1, 0, 0));
    // crossed limits: the lower clamp wins
    directed.push_back(reg_step(REG_SAT_HIGH, -5));
    directed.push_back(reg_step(REG_SAT_LOW, 5));
    directed.push_back(typed_step(0, 5));
    // zero inner dimension sums to zero; dead indexes are dropped
    directed.push_back(reg_step(REG_SAT_HIGH, 127));
    directed.push_back(reg_step(REG_SAT_LOW, -128));
    directed.push_back(reg_step(REG_INNER_DIM, 0));
    directed.push_back(reg_step(REG_UNUSED_LO, 255));
    directed.push_back(reg_step(REG_UNUSED_HI, 170));
    directed.push_back(typed_step(0, 0));
    // zero columns: nothing comes out
    directed.push_back(reg_step(REG_NUM_COLS, 0));
    directed.push_back(req_step(KIND_COMPUTE, 0, 0, 0));
    // oversized dimensions saturate to the store size
    directed.push_back(reg_step(REG_NUM_COLS, 127));
    directed.push_back(reg_step(REG_NUM_ROWS, 127));
    directed.push_back(reg_step(REG_INNER_DIM, 3));
    directed.push_back(req_step(KIND_COMPUTE, 63, 0, 0));
    // zero rows: every compute is out of range
    directed.push_back(reg_step(REG_NUM_ROWS, 0));
    directed.push_back(req_step(KIND_COMPUTE, 0, 0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].op == STEP_REG_WRITE) begin
        if (!prev_reg) settle();
        write_reg(directed[i].row[CIDX_BITS-1:0], directed[i].data);
        prev_reg = 1'b1;
      end else begin
        send_request(directed[i].kind, directed[i].row, directed[i].col, directed[i].data,
                     directed[i].typed, directed[i].typed_value);
        prev_reg = 1'b0;
      end
    end

    // Random phases: fresh register settings each phase, then mostly loads
    // into the live part of A and B with a compute now and then.
    for (p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 55;
        default: idle_pct = 18;
      endcase

      r = $urandom_range(99);
      if (r < 20) s = 0;
      else if (r < 80) s = $urandom_range(12, 1);
      else if (r < 90) s = $urandom_range(30, 13);
      else s = 31;
      shift_raw = {3'($urandom_range(7)), 5'(s)};

      if (p == 1) begin
        // one phase at full size in every direction
        rows_raw  = 8'd64;
        inner_raw = 8'd64;
        cols_raw  = 8'd200;
      end else if (p == 4) begin
        rows_raw  = 8'd1;
        inner_raw = 8'd1;
        cols_raw  = 8'd1;
        shift_raw = 8'hff;
      end else begin
        rows_raw  = pick_dim();
        inner_raw = pick_dim();
        cols_raw  = pick_dim();
      end

      r = $urandom_range(99);
      if (r < 50) begin
        hi = 8'sd127;
        lo = -8'sd128;
      end else begin
        hi = 8'($urandom_range(255));
        lo = 8'($urandom_range(255));
        // keep most pairs ordered; the rest may cross
        if (r < 85 && lo > hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end

      settle();
      write_reg(REG_SHIFT, shift_raw);
      write_reg(REG_NUM_ROWS, rows_raw);
      write_reg(REG_INNER_DIM, inner_raw);
      write_reg(REG_NUM_COLS, cols_raw);
      write_reg(REG_SAT_HIGH, hi);
      write_reg(REG_SAT_LOW, lo);
      write_reg(($urandom_range(1) != 0) ? REG_UNUSED_HI : REG_UNUSED_LO,
                8'($urandom_range(255)));

      n_rows  = eff_dim(cur_rows);
      n_inner = eff_dim(cur_inner);
      n_cols  = eff_dim(cur_cols);
      counted = 0;
      while (counted < REQS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 4) begin
          send_request(KIND_UNUSED, pick_idx(0), pick_idx(0), pick_val(), 1'b0, '0);
        end else begin
          if (r < 46) begin
            send_request(KIND_LOAD_A, pick_idx(n_rows), pick_idx(n_inner), pick_val(),
                         1'b0, '0);
          end else if (r < 86) begin
            send_request(KIND_LOAD_B, pick_idx(n_inner), pick_idx(n_cols), pick_val(),
                         1'b0, '0);
          end else begin
            // column and value are don't-cares here, so they stay random
            send_request(KIND_COMPUTE, pick_idx(n_rows), IDX_BITS'($urandom_range(63)),
                         pick_val(), 1'b0, '0);
          end
          counted++;
        end
        idle_gap(idle_pct);
      end
    end

    // drain: everything queued must come out, then nothing more
    start <= 1'b0;
    while (pending_elems.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_elems.size() != 0) begin
      report_mismatch($sformatf("%0d elements never arrived", pending_elems.size()));
    end
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
